// File: src/glu_pkg.sv
// Package for the GCD/LCM unit: payload types, sequencer states, width default.
package glu_pkg;

  localparam int GLU_DATA_WIDTH = 64;

  typedef struct packed {
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } glu_in_t;

  typedef struct packed {
    logic [63:0] gcd_value;
    logic [62:0] lcm_value;
    logic        lcm_overflow;
  } glu_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GDIV,
    ST_QDIV,
    ST_MUL,
    ST_DONE
  } glu_state_t;

endpackage

// File: src/gcd_lcm_unit.sv
// GCD and LCM unit: Euclid over a shared radix-2 divider, then a shift-add multiply.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+----------------------------
//   in      | input     | in_valid/stall| glu_in_t  (operand_a, b)
//   out     | output    | out_valid/stall| glu_out_t (gcd, lcm, flag)
//
// Steps: the operands are accepted, then each remainder is worked out on the
// one shift-subtract divider; Euclid runs at most about 1.44*DATA_WIDTH
// remainders, and then the zero remainder is seen. Then one more division
// |a|/g and a shift-add multiply, then the result beat.
// Reset clears the sequencer and the result valid. A stalled result holds;
// the input is taken again once the result has been delivered.
module gcd_lcm_unit #(
  parameter int DATA_WIDTH = glu_pkg::GLU_DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  glu_pkg::glu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output glu_pkg::glu_out_t out_data
);
  import glu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam int IW = $clog2(W);
  localparam logic [W-1:0] LIMIT = {1'b0, {(W-1){1'b1}}};

  glu_state_t state, state_next;

  logic [W-1:0] ma, mb;          // operand magnitudes
  logic [W-1:0] x, y;            // Euclid pair
  logic [W-1:0] dvd, dvs, quo;   // divider dividend/quotient shift, divisor
  logic [W:0]   rem;             // partial remainder
  logic [CW-1:0] cnt;
  logic [2*W-1:0] prod;          // multiply accumulator
  logic [W-1:0] mcand;
  logic         ovf;

  logic [W-1:0] raw_a, raw_b;
  logic [W:0]   rem_sh, rem_sub;
  logic         div_last;

  assign raw_a = in_data.operand_a[W-1:0];
  assign raw_b = in_data.operand_b[W-1:0];
  assign rem_sh  = {rem[W-1:0], dvd[W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign div_last = (cnt == CW'(W - 1));
  // flag an lcm above the signed range straight from the finished product
  assign ovf = (prod[2*W-1:W] != '0) || (prod[W-1:0] > LIMIT);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_GDIV;
      ST_GDIV: if (y == '0) state_next = (ma != '0 && mb != '0) ? ST_QDIV : ST_DONE;
      ST_QDIV: if (div_last) state_next = ST_MUL;
      ST_MUL:  if (cnt == CW'(W - 1)) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    out_data.gcd_value    = 64'(x);
    out_data.lcm_value    = ovf ? '0 : 63'(prod[W-1:0]);
    out_data.lcm_overflow = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ma   <= raw_a[W-1] ? -raw_a : raw_a;
        mb   <= raw_b[W-1] ? -raw_b : raw_b;
        x    <= raw_a[W-1] ? -raw_a : raw_a;
        y    <= raw_b[W-1] ? -raw_b : raw_b;
        dvd  <= raw_a[W-1] ? -raw_a : raw_a;
        dvs  <= raw_b[W-1] ? -raw_b : raw_b;
        rem  <= '0;
        cnt  <= '0;
        prod <= '0;
      end
      ST_GDIV: begin
        if (y == '0) begin
          // start |a|/g; g is x here
          dvd <= ma;
          dvs <= x;
          rem <= '0;
          cnt <= '0;
        end else if (div_last) begin
          // last restoring step: advance the Euclid pair to (y, x mod y)
          x   <= y;
          y   <= !rem_sub[W] ? rem_sub[W-1:0] : rem_sh[W-1:0];
          dvd <= y;
          dvs <= !rem_sub[W] ? rem_sub[W-1:0] : rem_sh[W-1:0];
          rem <= '0;
          cnt <= '0;
        end else begin
          // one restoring step; remainder lands after W steps
          if (!rem_sub[W]) rem <= rem_sub;
          else             rem <= rem_sh;
          dvd <= {dvd[W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
      end
      ST_QDIV: begin
        if (!rem_sub[W]) rem <= rem_sub;
        else             rem <= rem_sh;
        dvd <= {dvd[W-2:0], 1'b0};
        quo <= {quo[W-2:0], !rem_sub[W]};
        if (div_last) begin
          mcand <= {quo[W-2:0], !rem_sub[W]};
          cnt   <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_MUL: begin
        // add mb shifted by bit position cnt of the quotient
        if (mcand[cnt[IW-1:0]]) prod <= prod + ({{W{1'b0}}, mb} << cnt);
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.lcm_overflow) |-> (out_data.lcm_value == '0))
    else $error("overflowed lcm not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule
